/* sv/hofw_pkg.sv */
// hofw_pkg: shared types and constants of the overlapped Hann frame windower.
// No dependencies; used by the controller, datapath and top level.
package hofw_pkg;

	localparam int WINDOW_SIZE_DEF = 64;
	localparam int SAMPLE_W        = 16;
	localparam int COEF_W          = 17;
	localparam int POS_W           = 6;
	localparam int STEP_W          = 16;
	localparam int FRAC_W          = 15;
	localparam int PROD_W          = SAMPLE_W + COEF_W + 1;

	localparam logic [STEP_W-1:0] STEP_SIZE_RST = 16'd32;

	// fixed-point constants for the coefficient table (Q30; COEF_ONE is 1.0 in Q15)
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] COEF_ONE = 64'd32768;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] windowed_sample;
		logic [POS_W-1:0]           frame_position;
		logic                       frame_last;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic issue;
		logic last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic frame_due;
		logic pipe_en;
	} status_t;

endpackage

/* sv/hofw_stream_if.sv */
// hofw_stream_if: valid/ready stream channel carrying one payload word.
// Depends on nothing; the payload type is set per instance.
interface hofw_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/hofw_ctrl.sv */
// hofw_ctrl: state machine that takes samples and sequences frame read-out.
// Depends on hofw_pkg (cmd_t, status_t).
module hofw_ctrl #(
	parameter int WINDOW_SIZE = hofw_pkg::WINDOW_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  hofw_pkg::status_t          status,
	output hofw_pkg::cmd_t             cmd,
	output logic [$clog2(WINDOW_SIZE)-1:0] rd_idx
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam logic [AW-1:0] IDX_LAST = AW'(WINDOW_SIZE - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t        state_q;
	logic [AW-1:0] idx_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.take  = in_valid && (state_q == ST_IDLE);
	assign cmd.issue = (state_q == ST_EMIT) && status.pipe_en;
	assign cmd.last  = (idx_q == IDX_LAST);
	assign rd_idx    = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take && status.frame_due) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (cmd.issue) begin
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/hofw_datapath.sv */
// hofw_datapath: sample ring, hop counter, Hann table and windowing pipeline.
// Depends on hofw_pkg; driven by hofw_ctrl through cmd_t / status_t.
module hofw_datapath #(
	parameter int WINDOW_SIZE = hofw_pkg::WINDOW_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [hofw_pkg::STEP_W-1:0]            cfg_wdata,
	input  logic signed [hofw_pkg::SAMPLE_W-1:0]   sample,
	input  hofw_pkg::cmd_t                         cmd,
	input  logic [$clog2(WINDOW_SIZE)-1:0]         rd_idx,
	output hofw_pkg::status_t                      status,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output hofw_pkg::out_word_t                    out_word
);

	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int SW = hofw_pkg::SAMPLE_W;
	localparam int CW = hofw_pkg::COEF_W;
	localparam int PW = hofw_pkg::PROD_W;
	localparam int RW = PW - hofw_pkg::FRAC_W + 1;
	localparam logic [AW-1:0] POS_LAST = AW'(WINDOW_SIZE - 1);
	localparam logic [AW:0]   WSIZE    = (AW+1)'(WINDOW_SIZE);
	localparam logic [63:0]   M        = 64'(WINDOW_SIZE - 1);

	// symmetric Hann table: sin^2(pi*k/M) from a truncated Q30 sine series
	logic [CW-1:0] coef_rom [WINDOW_SIZE];

	for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_coef
		localparam logic [63:0] K  = 64'(k);
		localparam logic [63:0] J  = (K < M - K) ? K : M - K;
		localparam logic [63:0] X  = (hofw_pkg::PI_Q30 * J) / M;
		localparam logic [63:0] X2 = (X * X) >> 30;
		localparam logic [63:0] T1 = ((X * X2) >> 30) / 6;
		localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 20;
		localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 42;
		localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 72;
		localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 110;
		localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 156;
		localparam logic [63:0] SP = X + T2 + T4 + T6;
		localparam logic [63:0] SN = T1 + T3 + T5;
		localparam logic [63:0] SD = (SP < SN) ? 64'd0 : SP - SN;
		localparam logic [63:0] S  = (SD > hofw_pkg::ONE_Q30) ? hofw_pkg::ONE_Q30 : SD;
		localparam logic [63:0] C  = (S * S + (64'd1 << 44)) >> 45;
		localparam logic [63:0] CC = (C > hofw_pkg::COEF_ONE) ? hofw_pkg::COEF_ONE : C;
		assign coef_rom[k] = CW'(CC);
	end

	// registers
	logic [hofw_pkg::STEP_W-1:0] step_q;
	logic [hofw_pkg::STEP_W-1:0] hop_q;
	logic [hofw_pkg::STEP_W-1:0] hop_next;
	logic [AW-1:0]               wp_q;
	logic signed [SW-1:0]        ring_mem [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0]      ring_vld_q;

	assign hop_next         = hop_q + 1'b1;
	assign status.frame_due = (hop_next == step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= hofw_pkg::STEP_SIZE_RST;
			hop_q      <= '0;
			wp_q       <= '0;
			ring_vld_q <= '0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			if (cmd.take) begin
				hop_q            <= status.frame_due ? '0 : hop_next;
				wp_q             <= (wp_q == POS_LAST) ? '0 : wp_q + 1'b1;
				ring_vld_q[wp_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ring_mem[wp_q] <= sample;
		end
	end

	// ring address: oldest sample sits at the write position
	logic [AW:0]   addr_sum;
	logic [AW:0]   addr_wrap;
	logic [AW-1:0] rd_addr;

	assign addr_sum  = {1'b0, wp_q} + {1'b0, rd_idx};
	assign addr_wrap = (addr_sum >= WSIZE) ? addr_sum - WSIZE : addr_sum;
	assign rd_addr   = addr_wrap[AW-1:0];

	// pipeline advances whenever the output slot is free or being drained
	logic pipe_en;
	assign pipe_en        = !out_valid || out_ready;
	assign status.pipe_en = pipe_en;

	logic                 vld_s1, vld_s2, vld_q;
	logic signed [SW-1:0] smp_s1;
	logic                 wrt_s1;
	logic [CW-1:0]        coef_s1;
	logic [AW-1:0]        pos_s1, pos_s2;
	logic                 last_s1, last_s2;
	logic signed [PW-1:0] prod_s2;
	hofw_pkg::out_word_t  out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_q  <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			smp_s1 <= ring_mem[rd_addr];
		end
	end

	// round half up, then saturate
	logic signed [PW:0]   biased;
	logic signed [RW-1:0] shifted;
	logic signed [SW-1:0] sat;

	assign biased  = {prod_s2[PW-1], prod_s2} + (PW+1)'(16384);
	assign shifted = biased[PW:hofw_pkg::FRAC_W];

	always_comb begin
		priority if (shifted > RW'(32767)) begin
			sat = 16'sh7fff;
		end else if (shifted < -RW'(32768)) begin
			sat = 16'sh8000;
		end else begin
			sat = shifted[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			wrt_s1  <= ring_vld_q[rd_addr];
			coef_s1 <= coef_rom[rd_idx];
			pos_s1  <= rd_idx;
			last_s1 <= cmd.last;

			prod_s2 <= (wrt_s1 ? smp_s1 : SW'(0)) * $signed({1'b0, coef_s1});
			pos_s2  <= pos_s1;
			last_s2 <= last_s1;

			out_q.windowed_sample <= sat;
			out_q.frame_position  <= hofw_pkg::POS_W'(pos_s2);
			out_q.frame_last      <= last_s2;
		end
	end

	assign out_valid = vld_q;
	assign out_word  = out_q;

endmodule

/* sv/hann_overlap_frame_windower.sv */
// Overlapped Hann frame windower: ring of the last WINDOW_SIZE samples, one frame per hop.
// A sample that completes a hop holds input ready low until all WINDOW_SIZE read-outs of the
// frame have issued, one per cycle while the sink does not stall.
// The first result of a frame passes the s1, s2 and output registers; then one word/cycle
// while the sink is ready. Reset (arst_n, async): ring reads as zeros until written,
// write position and hop count zero, step_size 32.
module hann_overlap_frame_windower #(
	parameter int WINDOW_SIZE = hofw_pkg::WINDOW_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hofw_pkg::STEP_W-1:0]    cfg_wdata,
	hofw_stream_if.sink                    audio,
	hofw_stream_if.source                  windowed
);

	localparam int AW = $clog2(WINDOW_SIZE);

	hofw_pkg::cmd_t      cmd;
	hofw_pkg::status_t   status;
	logic [AW-1:0]       rd_idx;
	hofw_pkg::in_word_t  in_word;
	hofw_pkg::out_word_t out_word;
	logic                out_valid;

	assign in_word = audio.data;

	hofw_ctrl #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (audio.valid),
		.in_ready (audio.ready),
		.status   (status),
		.cmd      (cmd),
		.rd_idx   (rd_idx)
	);

	hofw_datapath #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample    (in_word.sample),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.status    (status),
		.out_ready (windowed.ready),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

	assign windowed.valid = out_valid;
	assign windowed.data  = out_word;

endmodule
